// ===== src/pdd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types and constants of the primer dimer detector: defaults, input
// kind and status codes, sequencer states and the scan unit's control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pdd_pkg;

    localparam int DEF_MAX_PRIMERS   = 4096;
    localparam int DEF_PRIMER_LENGTH = 25;
    localparam int DEF_MAX_TAIL      = 12;

    // tail length / mismatch values (MAX_TAIL tops out at 16)
    localparam int TLW = 5;

    localparam int IDXW = 12;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;

    localparam logic CFG_TAIL_LENGTH  = 1'b0;
    localparam logic CFG_MAX_MISMATCH = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_RD_A    = 6'b000010,
        ST_RD_B    = 6'b000100,
        ST_RD_LAST = 6'b001000,
        ST_SCAN    = 6'b010000,
        ST_DONE    = 6'b100000
    } t_state;

    typedef struct packed {
        logic       start;
        logic [3:0] tail_length;
        logic [3:0] max_mismatch;
    } t_scan_req;

    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_rsp;

endpackage

`default_nettype wire

// ===== src/pdd_scan.sv =====
// ----------------------------------------------------------------------------
// pdd_scan
// Iterative window scan: one shared window comparator tests one tail window
// per cycle, first primer a against b's tail, then b against a's tail.
// ----------------------------------------------------------------------------
`default_nettype none

module pdd_scan #(
    parameter int PRIMER_LENGTH = pdd_pkg::DEF_PRIMER_LENGTH,
    parameter int MAX_TAIL      = pdd_pkg::DEF_MAX_TAIL
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire pdd_pkg::t_scan_req         i_req,
    input  wire logic [2*PRIMER_LENGTH-1:0] i_seq_a,
    input  wire logic [2*PRIMER_LENGTH-1:0] i_seq_b,
    output pdd_pkg::t_scan_rsp              o_rsp
);
    import pdd_pkg::*;

    localparam int SW  = 2 * PRIMER_LENGTH;
    localparam int LPW = $clog2(PRIMER_LENGTH + 1);
    localparam int PW  = (LPW > TLW) ? LPW : TLW;

    logic          r_busy;
    logic          r_dir;
    logic          r_done;
    logic          r_hit;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_nw;
    logic [PW-1:0] r_t;
    logic [3:0]    r_m;
    logic [SW-1:0] r_a;
    logic [SW-1:0] r_b;
    logic [SW-1:0] r_sh;

    logic [PW-1:0]       t_sat;
    logic                cfg_ok;
    logic [SW-1:0]       tail_src;
    logic [1:0]          rc      [MAX_TAIL];
    logic [MAX_TAIL-1:0] diff;
    logic [TLW-1:0]      n_diffs;
    logic                hit_now;

    always_comb begin
        if (PW'(i_req.tail_length) > PW'(MAX_TAIL)) begin
            t_sat = PW'(MAX_TAIL);
        end else begin
            t_sat = PW'(i_req.tail_length);
        end
        cfg_ok = (t_sat != '0) && (PW'(i_req.max_mismatch) < t_sat)
                 && (t_sat < PW'(PRIMER_LENGTH));
    end

    // tail side of the current direction
    assign tail_src = r_dir ? r_a : r_b;

    // reverse complement of the tail, element i from base LEN-1-i
    for (genvar gi = 0; gi < MAX_TAIL; gi++) begin : g_rc
        if (gi < PRIMER_LENGTH) begin : g_in
            assign rc[gi] = tail_src[2*(PRIMER_LENGTH-1-gi) +: 2] ^ 2'b01;
        end else begin : g_out
            assign rc[gi] = 2'b00;
        end
    end

    // element 0 must match exactly; others counted while below tail length
    assign diff[0] = 1'b0;
    for (genvar gi = 1; gi < MAX_TAIL; gi++) begin : g_diff
        if (gi < PRIMER_LENGTH) begin : g_in
            assign diff[gi] = (PW'(gi) < r_t) && (r_sh[2*gi +: 2] != rc[gi]);
        end else begin : g_out
            assign diff[gi] = 1'b0;
        end
    end

    always_comb begin
        n_diffs = '0;
        for (int k = 0; k < MAX_TAIL; k++) begin
            n_diffs = n_diffs + TLW'(diff[k]);
        end
        hit_now = (r_sh[1:0] == rc[0]) && (n_diffs <= TLW'(r_m));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dir  <= 1'b0;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a   <= i_seq_a;
                r_b   <= i_seq_b;
                r_sh  <= i_seq_a >> 2;
                r_t   <= t_sat;
                r_m   <= i_req.max_mismatch;
                r_nw  <= PW'(PRIMER_LENGTH) - t_sat;
                r_pos <= PW'(1);
                r_dir <= 1'b0;
                if (cfg_ok) begin
                    r_busy <= 1'b1;
                end else begin
                    r_done <= 1'b1;
                    r_hit  <= 1'b0;
                end
            end else if (r_busy) begin
                if (hit_now) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_hit  <= 1'b1;
                end else if (r_pos == r_nw) begin
                    if (!r_dir) begin
                        r_dir <= 1'b1;
                        r_pos <= PW'(1);
                        r_sh  <= r_b >> 2;
                    end else begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_hit  <= 1'b0;
                    end
                end else begin
                    r_pos <= r_pos + PW'(1);
                    r_sh  <= r_sh >> 2;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hit  = r_hit;

endmodule

`default_nettype wire

// ===== src/primer_dimer_detector_core.sv =====
// ----------------------------------------------------------------------------
// primer_dimer_detector_core
// Primer store with pair queries that flag possible primer dimers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   load a primer, query a stored pair, or clear the store. Every command
//   yields exactly one result transfer on (o_out_valid / i_out_stall).
//   Config port: i_cfg_we writes i_cfg_data into tail_length (index 0) or
//   max_mismatch (index 1); write only while the block is idle.
// Sequence:
//   Load, clear, unused kind, query of an unloaded index: staging register,
//   then output register. Query: two primer memory reads, then W windows,
//   W = windows tried, at most 2*(PRIMER_LENGTH - tail), fewer on an early
//   hit, 0 when the settings allow no match. The single window comparator
//   in pdd_scan tests one window per cycle. One command in flight; the
//   input stall drops as the result is loaded into the output register.
// Reset:
//   Synchronous, active low. Loaded count clears, config returns to
//   tail_length 5 / max_mismatch 1. Primer memory is not cleared; only
//   entries below the loaded count are ever used by a query.
// Stall:
//   A finished result sits in the output register while stalled; the core
//   may finish one more command into its staging register behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module primer_dimer_detector_core #(
    parameter int MAX_PRIMERS   = pdd_pkg::DEF_MAX_PRIMERS,
    parameter int PRIMER_LENGTH = pdd_pkg::DEF_PRIMER_LENGTH,
    parameter int MAX_TAIL      = pdd_pkg::DEF_MAX_TAIL
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // config write port
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_index,
    input  wire logic [3:0]                 i_cfg_data,
    // command channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_kind,
    input  wire logic [2*PRIMER_LENGTH-1:0] i_sequence_req,
    input  wire logic [pdd_pkg::IDXW-1:0]   i_first_index,
    input  wire logic [pdd_pkg::IDXW-1:0]   i_second_index,
    // result channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_dimer,
    output logic [pdd_pkg::IDXW-1:0]        o_stored_index,
    output logic [1:0]                      o_status
);
    import pdd_pkg::*;

    localparam int SW   = 2 * PRIMER_LENGTH;
    localparam int AW   = (MAX_PRIMERS > 1) ? $clog2(MAX_PRIMERS) : 1;
    localparam int CW   = $clog2(MAX_PRIMERS + 1);
    localparam int CMPW = (CW > IDXW) ? CW : IDXW;

    // primer memory, one write port and one read port
    logic [SW-1:0] mem [MAX_PRIMERS];

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count;
    logic [3:0]      r_tail_length;
    logic [3:0]      r_max_mismatch;
    logic [AW-1:0]   r_fa;
    logic [AW-1:0]   r_fb;
    logic [SW-1:0]   r_rd_data;
    logic [SW-1:0]   r_pa;
    // staged result
    logic            r_res_dimer;
    logic [IDXW-1:0] r_res_index;
    logic [1:0]      r_res_status;
    // output register
    logic            r_out_valid;
    logic            r_out_dimer;
    logic [IDXW-1:0] r_out_index;
    logic [1:0]      r_out_status;

    logic          accept;
    logic          mem_we;
    logic [AW-1:0] rd_addr;
    logic          store_full;
    logic          idx_bad;
    logic          out_load;
    t_scan_req     scan_req;
    t_scan_rsp     scan_rsp;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign store_full = !(CMPW'(r_count) < CMPW'(MAX_PRIMERS));
    assign idx_bad    = !(CMPW'(i_first_index) < CMPW'(r_count))
                        || !(CMPW'(i_second_index) < CMPW'(r_count));
    assign mem_we     = accept && (i_kind == KIND_LOAD) && !store_full;
    assign rd_addr    = (r_state == ST_RD_B) ? r_fb : r_fa;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[AW'(r_count)] <= i_sequence_req;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign scan_req.start        = (r_state == ST_RD_LAST);
    assign scan_req.tail_length  = r_tail_length;
    assign scan_req.max_mismatch = r_max_mismatch;

    pdd_scan #(
        .PRIMER_LENGTH (PRIMER_LENGTH),
        .MAX_TAIL      (MAX_TAIL)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scan_req),
        .i_seq_a (r_pa),
        .i_seq_b (r_rd_data),
        .o_rsp   (scan_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_QUERY && !idx_bad) begin
                        n_state = ST_RD_A;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RD_A:    n_state = ST_RD_B;
            ST_RD_B:    n_state = ST_RD_LAST;
            ST_RD_LAST: n_state = ST_SCAN;
            ST_SCAN: begin
                if (scan_rsp.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_count        <= '0;
            r_tail_length  <= 4'd5;
            r_max_mismatch <= 4'd1;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TAIL_LENGTH) begin
                    r_tail_length <= i_cfg_data;
                end else begin
                    r_max_mismatch <= i_cfg_data;
                end
            end
            if (mem_we) begin
                r_count <= r_count + CW'(1);
            end else if (accept && i_kind == KIND_CLEAR) begin
                r_count <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: staging and output registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fa         <= AW'(i_first_index);
            r_fb         <= AW'(i_second_index);
            r_res_dimer  <= 1'b0;
            r_res_index  <= '0;
            r_res_status <= STATUS_OK;
            case (i_kind)
                KIND_LOAD: begin
                    if (store_full) begin
                        r_res_status <= STATUS_FULL;
                    end else begin
                        r_res_index <= IDXW'(r_count);
                    end
                end
                KIND_QUERY: begin
                    if (idx_bad) begin
                        r_res_status <= STATUS_NOT_LOADED;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == ST_RD_B) begin
            r_pa <= r_rd_data;
        end
        if (r_state == ST_SCAN && scan_rsp.done) begin
            r_res_dimer <= scan_rsp.hit;
        end
        if (out_load) begin
            r_out_dimer  <= r_res_dimer;
            r_out_index  <= r_res_index;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_dimer        = r_out_dimer;
    assign o_stored_index = r_out_index;
    assign o_status       = r_out_status;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for primer_dimer_detector_core. A scoreboard mirrors the
// primer store, loaded count and both config registers. It predicts one result
// per command transfer and checks each result transfer against it in order.
// Stimulus: directed corner cases, then random commands under several
// register settings. Random loads often plant a mutated reverse complement
// of a stored primer's tail so that hits are common. Both channels idle in
// random bursts.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pdd_pkg::*;

    localparam int PLEN         = DEF_PRIMER_LENGTH;
    localparam int SEQW         = 2 * PLEN;
    localparam int NPRIM        = DEF_MAX_PRIMERS;
    localparam int TMAX         = DEF_MAX_TAIL;
    localparam int QUIET_LIMIT  = 3000;   // cycles without any transfer
    localparam int DRAIN_CYCLES = 60;     // longer than the slowest query
    localparam int RANDOM_ITEMS = 1200;
    localparam int N_PHASES     = 10;

    // kind 3 has no meaning; the block must answer it with an all-zero result
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic            dimer;
        logic [IDXW-1:0] stored_index;
        logic [1:0]      status;
    } t_dimer_result;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the store and registers, queue of pending results
    // ------------------------------------------------------------------------
    class dimer_scoreboard;
        logic [SEQW-1:0] primers [NPRIM];
        int unsigned     n_loaded;
        logic [3:0]      tail_reg;
        logic [3:0]      mism_max;
        t_dimer_result   pending_q [$];
        int unsigned     n_errors;

        function new();
            n_loaded = 0;
            tail_reg = 4'd5;
            mism_max = 4'd1;
            n_errors = 0;
        endfunction

        function void set_register(logic idx, logic [3:0] val);
            if (idx == CFG_TAIL_LENGTH)
                tail_reg = val;
            else
                mism_max = val;
        endfunction

        // does any window of a (start 1 and up) match the revcomp of b's tail
        function bit tail_hits(logic [SEQW-1:0] a, logic [SEQW-1:0] b);
            int t;
            int diff;
            t = (tail_reg > TMAX) ? TMAX : int'(tail_reg);
            if (t == 0 || int'(mism_max) >= t || t >= PLEN)
                return 1'b0;
            for (int p = 1; p <= PLEN - t; p++) begin
                if (a[2*p +: 2] != (b[2*(PLEN-1) +: 2] ^ 2'b01))
                    continue;
                diff = 0;
                for (int i = 1; i < t; i++)
                    if (a[2*(p+i) +: 2] != (b[2*(PLEN-1-i) +: 2] ^ 2'b01))
                        diff++;
                if (diff <= int'(mism_max))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // called once per accepted command transfer
        function void note_command(logic [1:0] k, logic [SEQW-1:0] s,
                                   logic [IDXW-1:0] fa, logic [IDXW-1:0] fb);
            t_dimer_result r;
            r = '0;
            case (k)
                KIND_LOAD: begin
                    if (n_loaded < NPRIM) begin
                        primers[n_loaded] = s;
                        r.stored_index = IDXW'(n_loaded);
                        n_loaded++;
                    end else begin
                        r.status = STATUS_FULL;
                    end
                end
                KIND_QUERY: begin
                    if (fa >= n_loaded || fb >= n_loaded)
                        r.status = STATUS_NOT_LOADED;
                    else
                        r.dimer = tail_hits(primers[fa], primers[fb])
                                  || tail_hits(primers[fb], primers[fa]);
                end
                KIND_CLEAR: n_loaded = 0;
                default: ;
            endcase
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void flag(string msg);
            n_errors++;
            if (n_errors <= 10)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        // called once per accepted result transfer
        function void check_result(logic d, logic [IDXW-1:0] idx, logic [1:0] st);
            t_dimer_result want;
            if (pending_q.size() == 0) begin
                flag($sformatf("unexpected result dimer=%0d stored_index=%0d status=%0d",
                               d, idx, st));
                return;
            end
            want = pending_q.pop_front();
            if (d !== want.dimer)
                flag($sformatf("dimer expected %0d got %0d", want.dimer, d));
            if (idx !== want.stored_index)
                flag($sformatf("stored_index expected %0d got %0d",
                               want.stored_index, idx));
            if (st !== want.status)
                flag($sformatf("status expected %0d got %0d", want.status, st));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic            cfg_we     = 1'b0;
    logic            cfg_index  = 1'b0;
    logic [3:0]      cfg_data   = 4'd0;
    logic            in_valid   = 1'b0;
    logic [1:0]      kind       = 2'd0;
    logic [SEQW-1:0] seq        = '0;
    logic [IDXW-1:0] first_idx  = '0;
    logic [IDXW-1:0] second_idx = '0;
    logic            out_stall  = 1'b0;

    logic            in_stall;
    logic            out_valid;
    logic            dimer;
    logic [IDXW-1:0] stored_index;
    logic [1:0]      status;

    dimer_scoreboard sb;

    bit send_idle_en = 1'b1;   // sender inserts idle bursts
    bit stall_en     = 1'b1;   // receiver inserts stall bursts
    int stall_left   = 0;
    int quiet_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    primer_dimer_detector_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (kind),
        .i_sequence_req (seq),
        .i_first_index  (first_idx),
        .i_second_index (second_idx),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_dimer        (dimer),
        .o_stored_index (stored_index),
        .o_status       (status)
    );

    // ------------------------------------------------------------------------
    // Result side: check each transfer, then pick the next stall value.
    // Stall comes in random bursts.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(dimer, stored_index, status);
        if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (stall_en && $urandom_range(0, 3) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: a run that stops moving is a failure
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    task automatic pause_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // One command transfer. Valid stays up on return unless the sender paused,
    // so back-to-back commands go out with no gap; callers lower it when they pause.
    task automatic send(logic [1:0] k, logic [SEQW-1:0] s,
                        logic [IDXW-1:0] a, logic [IDXW-1:0] b);
        in_valid   <= 1'b1;
        kind       <= k;
        seq        <= s;
        first_idx  <= a;
        second_idx <= b;
        do @(posedge clk); while (in_stall);
        sb.note_command(k, s, a, b);
        if (send_idle_en && $urandom_range(0, 4) == 0)
            pause_sender($urandom_range(1, 6));
    endtask

    // Sender holds off until every pending result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    // Register writes only with the block idle
    task automatic apply_settings(logic [3:0] t, logic [3:0] m);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TAIL_LENGTH;
        cfg_data  <= t;
        @(posedge clk);
        sb.set_register(CFG_TAIL_LENGTH, t);
        cfg_index <= CFG_MAX_MISMATCH;
        cfg_data  <= m;
        @(posedge clk);
        sb.set_register(CFG_MAX_MISMATCH, m);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SEQW-1:0] random_seq();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[SEQW-1:0];
    endfunction

    function automatic logic [IDXW-1:0] random_idx();
        return IDXW'($urandom_range(0, NPRIM - 1));
    endfunction

    // Mostly a loaded index, biased toward the newest loads so that planted
    // partners get queried; now and then anything in the field's range.
    function automatic logic [IDXW-1:0] pick_index();
        int unsigned back;
        if (sb.n_loaded == 0 || $urandom_range(0, 9) == 0)
            return random_idx();
        if ($urandom_range(0, 1) == 0) begin
            back = $urandom_range(0, (sb.n_loaded > 8) ? 7 : sb.n_loaded - 1);
            return IDXW'(sb.n_loaded - 1 - back);
        end
        return IDXW'($urandom_range(0, sb.n_loaded - 1));
    endfunction

    // Random primer carrying the revcomp of b's tail at some window, with a
    // few bases flipped. Window 0 is used now and then; it must never count.
    function automatic logic [SEQW-1:0] make_partner(logic [SEQW-1:0] b);
        int              t;
        int              pos;
        int              j;
        logic [SEQW-1:0] s;
        t = (sb.tail_reg > TMAX) ? TMAX : int'(sb.tail_reg);
        if (t < 2)
            t = 5;
        pos = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, PLEN - t);
        s = random_seq();
        for (int i = 0; i < t; i++)
            s[2*(pos+i) +: 2] = b[2*(PLEN-1-i) +: 2] ^ 2'b01;
        for (int f = $urandom_range(0, 3); f > 0; f--) begin
            j = pos + $urandom_range(1, t - 1);
            s[2*j +: 2] = s[2*j +: 2] ^ 2'($urandom_range(1, 3));
        end
        return s;
    endfunction

    task automatic random_command();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 16)
            send(KIND_LOAD, random_seq(), random_idx(), random_idx());
        else if (r < 34 && sb.n_loaded > 0)
            send(KIND_LOAD, make_partner(sb.primers[$urandom_range(0, sb.n_loaded - 1)]),
                 random_idx(), random_idx());
        else if (r < 98)
            send(KIND_QUERY, random_seq(), pick_index(), pick_index());
        else if (r == 98)
            send(KIND_CLEAR, random_seq(), random_idx(), random_idx());
        else
            send(KIND_UNUSED, random_seq(), random_idx(), random_idx());
    endtask

    // Register settings per random phase: strict and saturated tails, tail
    // zero, mismatch limit at or above the tail, one-base tail.
    logic [3:0] phase_tail [N_PHASES] = '{4'd12, 4'd15, 4'd0, 4'd5, 4'd8,
                                          4'd6, 4'd1, 4'd13, 4'd10, 4'd5};
    logic [3:0] phase_mism [N_PHASES] = '{4'd0, 4'd2, 4'd0, 4'd5, 4'd3,
                                          4'd15, 4'd0, 4'd4, 4'd9, 4'd1};

    initial begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed, default registers (tail 5, one mismatch) ----
        send(KIND_LOAD, '0, '0, '0);                        // 0: all A
        send(KIND_LOAD, '1, '1, '1);                        // 1: all G
        send(KIND_LOAD, {PLEN{2'b01}}, '0, '0);             // 2: all T
        send(KIND_LOAD, {PLEN{2'b10}}, '0, '0);             // 3: all C
        send(KIND_QUERY, '0, 12'd0, 12'd2);                 // A vs T: hit
        send(KIND_QUERY, '0, 12'd3, 12'd1);                 // C vs G: hit
        send(KIND_QUERY, '0, 12'd0, 12'd1);                 // no hit
        send(KIND_QUERY, '0, 12'd1, 12'd1);                 // self, no hit
        send(KIND_QUERY, '0, 12'd4, 12'd0);                 // not loaded
        send(KIND_QUERY, '0, 12'd0, '1);                    // not loaded
        send(KIND_QUERY, '1, '1, '1);                       // not loaded
        send(KIND_UNUSED, '1, '1, '1);                      // all-zero result
        // CCCCA only at window 0 would match all-G's tail: must not hit
        send(KIND_LOAD, SEQW'('hAA), '0, '0);               // 4
        send(KIND_QUERY, '0, 12'd4, 12'd1);
        // same pattern moved to window 1: hit
        send(KIND_LOAD, SEQW'('h2A8), '0, '0);              // 5
        send(KIND_QUERY, '0, 12'd5, 12'd1);
        send(KIND_CLEAR, '0, '0, '0);
        send(KIND_QUERY, '0, 12'd0, 12'd0);                 // not loaded after clear
        send(KIND_LOAD, random_seq(), '0, '0);              // index restarts at 0

        // ---- random phases, each under its own register setting ----
        for (int ph = 0; ph < N_PHASES; ph++) begin
            apply_settings(phase_tail[ph], phase_mism[ph]);
            // every third phase runs with no idling; the last one as well
            send_idle_en = (ph % 3 != 1) && (ph != N_PHASES - 1);
            stall_en     = send_idle_en;
            repeat (RANDOM_ITEMS / N_PHASES)
                random_command();
        end

        // ---- drain and report ----
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.n_errors == 0 && sb.pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
